[rtl/core/amp_pkg.sv]
// shared types, codes and constants of the accept-map message parser
// used by amp_ctrl, amp_dpath and accept_map_message_parser
package amp_pkg;

  localparam int unsigned MaxSourcesDef = 8;

  localparam logic [7:0]  VersionRst    = 8'd1;
  localparam logic [15:0] FaderLimitRst = 16'd150;

  localparam int unsigned OutDataW = 56;
  localparam int unsigned BcntW    = 10;
  localparam logic [BcntW-1:0] BcntMax = {BcntW{1'b1}};

  // register indexes on the config port
  localparam logic RegVersion    = 1'b0;
  localparam logic RegFaderLimit = 1'b1;

  // verdict status codes
  localparam logic [3:0] StOk       = 4'd0;
  localparam logic [3:0] StShort    = 4'd1;
  localparam logic [3:0] StVersion  = 4'd2;
  localparam logic [3:0] StZeroCnt  = 4'd3;
  localparam logic [3:0] StLength   = 4'd4;
  localparam logic [3:0] StZeroGen  = 4'd5;
  localparam logic [3:0] StTooMany  = 4'd6;
  localparam logic [3:0] StZeroKey  = 4'd7;
  localparam logic [3:0] StFader    = 4'd8;
  localparam logic [3:0] StDupKey   = 4'd9;

  // result kinds
  localparam logic KindEntry   = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ENTRY,
    OUT_VERDICT,
    OUT_HELD
  } out_sel_e;

  typedef struct packed {
    logic     take;
    logic     hold_verdict;
    out_sel_e out_sel;
  } amp_cmd_t;

  typedef struct packed {
    logic entry_done;
  } amp_stat_t;

endpackage

[rtl/core/amp_ctrl.sv]
// controller of the accept-map message parser: handshakes and result sequencing
// depends on amp_pkg
module amp_ctrl
  import amp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  amp_stat_t stat_i,
  output amp_cmd_t  cmd_o
);

  localparam logic SRun  = 1'b0;
  localparam logic SVerd = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == SRun) && slot_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d            = state_q;
    out_valid_d        = out_valid_q && !out_ready_i;
    cmd_o.take         = 1'b0;
    cmd_o.hold_verdict = 1'b0;
    cmd_o.out_sel      = OUT_NONE;
    unique case (state_q)
      SRun: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.take = 1'b1;
          if (stat_i.entry_done) begin
            cmd_o.out_sel = OUT_ENTRY;
            out_valid_d   = 1'b1;
            if (in_last_i) begin
              cmd_o.hold_verdict = 1'b1;
              state_d            = SVerd;
            end
          end else if (in_last_i) begin
            cmd_o.out_sel = OUT_VERDICT;
            out_valid_d   = 1'b1;
          end
        end
      end
      SVerd: begin
        if (slot_free) begin
          cmd_o.out_sel = OUT_HELD;
          out_valid_d   = 1'b1;
          state_d       = SRun;
        end
      end
      default: state_d = SRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SRun;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/amp_dpath.sv]
// datapath of the accept-map message parser: message fields, key store, checks, result regs
// depends on amp_pkg
module amp_dpath
  import amp_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = MaxSourcesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  msg_byte_i,
  input  logic        eom_i,
  input  logic [7:0]  version_i,
  input  logic [15:0] fader_limit_i,
  input  amp_cmd_t    cmd_i,
  output amp_stat_t   stat_o,
  output logic        kind_o,
  output logic [2:0]  entry_index_o,
  output logic [7:0]  source_key_o,
  output logic [15:0] fader_id_o,
  output logic [15:0] generation_o,
  output logic [7:0]  source_count_o,
  output logic [3:0]  status_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam logic [7:0]  MaxSrc = 8'(MAX_SOURCES);

  // message state
  logic [BcntW-1:0] bcnt_q, bcnt_d;
  logic [15:0]      gen_q, gen_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       pkey_q, pkey_d;
  logic [7:0]       fhigh_q, fhigh_d;
  logic [7:0]       ecnt_q, ecnt_d;
  logic [3:0]       ferr_q, ferr_d;

  logic [7:0] key_store_q [MAX_SOURCES];

  logic [15:0]      fader;
  logic             entry_done;
  logic             dup;
  logic [3:0]       entry_err;
  logic             store_wr;
  logic [BcntW-1:0] exp_len;
  logic [3:0]       v_status;

  // held verdict, sent after the entry result of the same final byte
  logic [15:0] hgen_q;
  logic [7:0]  hcnt_q;
  logic [3:0]  hstat_q;

  // result register
  logic        kind_q;
  logic [2:0]  idx_q;
  logic [7:0]  key_q;
  logic [15:0] fid_q;
  logic [15:0] ogen_q;
  logic [7:0]  ocnt_q;
  logic [3:0]  ostat_q;
  logic        last_q;

  assign fader      = {fhigh_q, msg_byte_i};
  assign entry_done = (bcnt_q >= BcntW'(4)) && (phase_q == 2'd2);
  assign stat_o.entry_done = entry_done;
  assign store_wr   = cmd_i.take && entry_done && (ecnt_q < MaxSrc);

  // parallel compare against keys already stored in this message
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if ((8'(i) < ecnt_q) && (key_store_q[i] == pkey_q)) dup = 1'b1;
    end
  end

  always_comb begin
    if (pkey_q == 8'd0)              entry_err = StZeroKey;
    else if (fader >= fader_limit_i) entry_err = StFader;
    else if (dup)                    entry_err = StDupKey;
    else                             entry_err = StOk;
  end

  always_comb begin
    bcnt_d  = (bcnt_q == BcntMax) ? bcnt_q : bcnt_q + BcntW'(1);
    gen_d   = gen_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    pkey_d  = pkey_q;
    fhigh_d = fhigh_q;
    ecnt_d  = ecnt_q;
    ferr_d  = ferr_q;
    if (bcnt_q == BcntW'(0)) begin
      if ((msg_byte_i != version_i) && (ferr_q == StOk)) ferr_d = StVersion;
    end else if (bcnt_q == BcntW'(1)) begin
      gen_d = {msg_byte_i, gen_q[7:0]};
    end else if (bcnt_q == BcntW'(2)) begin
      gen_d = {gen_q[15:8], msg_byte_i};
    end else if (bcnt_q == BcntW'(3)) begin
      cnt_d = msg_byte_i;
    end else if (phase_q == 2'd0) begin
      pkey_d  = msg_byte_i;
      phase_d = 2'd1;
    end else if (phase_q == 2'd1) begin
      fhigh_d = msg_byte_i;
      phase_d = 2'd2;
    end else begin
      phase_d = 2'd0;
      if ((entry_err != StOk) && (ferr_q == StOk)) ferr_d = entry_err;
      if (ecnt_q != 8'hff) ecnt_d = ecnt_q + 8'd1;
    end
  end

  // verdict from the state as it stands after this byte
  assign exp_len = BcntW'(4) + BcntW'({cnt_d, 1'b0}) + BcntW'(cnt_d);

  always_comb begin
    if (bcnt_d < BcntW'(4))       v_status = StShort;
    else if (ferr_d == StVersion) v_status = StVersion;
    else if (cnt_d == 8'd0)       v_status = StZeroCnt;
    else if (bcnt_d != exp_len)   v_status = StLength;
    else if (gen_d == 16'd0)      v_status = StZeroGen;
    else if (cnt_d > MaxSrc)      v_status = StTooMany;
    else                          v_status = ferr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q  <= '0;
      gen_q   <= '0;
      cnt_q   <= '0;
      phase_q <= '0;
      pkey_q  <= '0;
      fhigh_q <= '0;
      ecnt_q  <= '0;
      ferr_q  <= StOk;
    end else if (cmd_i.take) begin
      if (eom_i) begin
        bcnt_q  <= '0;
        gen_q   <= '0;
        cnt_q   <= '0;
        phase_q <= '0;
        pkey_q  <= '0;
        fhigh_q <= '0;
        ecnt_q  <= '0;
        ferr_q  <= StOk;
      end else begin
        bcnt_q  <= bcnt_d;
        gen_q   <= gen_d;
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
        pkey_q  <= pkey_d;
        fhigh_q <= fhigh_d;
        ecnt_q  <= ecnt_d;
        ferr_q  <= ferr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) key_store_q[ecnt_q[IdxW-1:0]] <= pkey_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_verdict) begin
      hgen_q  <= gen_d;
      hcnt_q  <= cnt_d;
      hstat_q <= v_status;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.out_sel)
      OUT_ENTRY: begin
        kind_q  <= KindEntry;
        idx_q   <= ecnt_q[2:0];
        key_q   <= pkey_q;
        fid_q   <= fader;
        ogen_q  <= '0;
        ocnt_q  <= '0;
        ostat_q <= StOk;
        last_q  <= 1'b0;
      end
      OUT_VERDICT: begin
        kind_q  <= KindVerdict;
        idx_q   <= '0;
        key_q   <= '0;
        fid_q   <= '0;
        ogen_q  <= gen_d;
        ocnt_q  <= cnt_d;
        ostat_q <= v_status;
        last_q  <= 1'b1;
      end
      OUT_HELD: begin
        kind_q  <= KindVerdict;
        idx_q   <= '0;
        key_q   <= '0;
        fid_q   <= '0;
        ogen_q  <= hgen_q;
        ocnt_q  <= hcnt_q;
        ostat_q <= hstat_q;
        last_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign kind_o         = kind_q;
  assign entry_index_o  = idx_q;
  assign source_key_o   = key_q;
  assign fader_id_o     = fid_q;
  assign generation_o   = ogen_q;
  assign source_count_o = ocnt_q;
  assign status_o       = ostat_q;
  assign last_o         = last_q;

endmodule

[rtl/core/accept_map_message_parser.sv]
// top level of the accept-map message parser: config registers, controller and datapath
// depends on amp_pkg, amp_ctrl and amp_dpath
//
// usage
//   input stream: one message byte per request on s_axis_tdata_i, tlast marks the
//   final byte. a byte that completes a key/fader triple gives an entry result
//   (tuser 0); the final byte also gives a verdict (tuser 1, tlast 1) carrying
//   generation, count byte and the first failing check.
//   config: apb port, protocol_version at 0x0, fader_limit at 0x4; write only
//   while the parser is idle. pready is always high.
// timing
//   a byte's result is loaded into the output register when the byte is taken
//   and shows in the next cycle. sustained rate is one byte per cycle while the
//   receiver keeps up. a final byte that also ends a triple gives two results
//   via the single output register; the input holds off while the verdict follows.
// reset and stall
//   reset clears the message state, the output valid and sets the config
//   registers to 1 and 150. the key store is not cleared; only keys written in
//   the current message are compared. when the receiver stalls the result
//   holds and the input stops taking bytes until the output slot frees.
module accept_map_message_parser
  import amp_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = MaxSourcesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] msg_byte
  input  logic        s_axis_tlast_i,   // end_of_message
  // master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] entry_index, [10:3] source_key, [26:11] fader_id, [42:27] generation,
  // [50:43] source_count, [54:51] status, [55] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // [0] kind
  output logic        m_axis_tlast_o,   // last
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  version_q;
  logic [15:0] fader_limit_q;
  logic        cfg_wr;

  amp_cmd_t  cmd;
  amp_stat_t stat;

  logic [2:0]  entry_index;
  logic [7:0]  source_key;
  logic [15:0] fader_id;
  logic [15:0] generation;
  logic [7:0]  source_count;
  logic [3:0]  status;

  // config registers, word address taken from paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q     <= VersionRst;
      fader_limit_q <= FaderLimitRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegVersion:    version_q     <= pwdata[7:0];
        RegFaderLimit: fader_limit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegVersion:    prdata = {24'd0, version_q};
      RegFaderLimit: prdata = {16'd0, fader_limit_q};
      default:       prdata = '0;
    endcase
  end

  amp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  amp_dpath #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .msg_byte_i     (s_axis_tdata_i),
    .eom_i          (s_axis_tlast_i),
    .version_i      (version_q),
    .fader_limit_i  (fader_limit_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_o         (m_axis_tuser_o),
    .entry_index_o  (entry_index),
    .source_key_o   (source_key),
    .fader_id_o     (fader_id),
    .generation_o   (generation),
    .source_count_o (source_count),
    .status_o       (status),
    .last_o         (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, status, source_count, generation, fader_id,
                           source_key, entry_index};

endmodule

[tb/amp_checker.sv]
`timescale 1ns / 1ps
// result checker of the accept-map message parser: predicts every result from the
// accepted bytes and config writes and compares the results on the output stream
// depends on amp_pkg
module amp_checker
  import amp_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = MaxSourcesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [7:0]          s_data_i,
  input  logic                s_last_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,
  input  logic                m_user_i,
  input  logic                m_last_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned TripleBytes = 3;

  typedef enum logic [1:0] {
    TRIP_KEY,
    TRIP_FADER_HI,
    TRIP_FADER_LO
  } triple_e;

  typedef struct packed {
    logic        kind;
    logic [2:0]  entry_index;
    logic [7:0]  source_key;
    logic [15:0] fader_id;
    logic [15:0] generation;
    logic [7:0]  source_count;
    logic [3:0]  status;
    logic        last;
  } amp_result_t;

  // config copy
  logic [7:0]  version_q;
  logic [15:0] fader_limit_q;

  // message state
  logic [BcntW-1:0] byte_cnt;
  logic [15:0]      gen_q;
  logic [7:0]       count_q;
  triple_e          triple_q;
  logic [7:0]       key_q;
  logic [7:0]       fader_hi_q;
  logic [7:0]       entries;
  logic [7:0]       key_mem [MAX_SOURCES];
  logic [3:0]       first_err;

  amp_result_t awaited_results[$];
  int unsigned fails;

  initial fails = 0;

  function automatic void clear_message();
    byte_cnt   = '0;
    gen_q      = '0;
    count_q    = '0;
    triple_q   = TRIP_KEY;
    key_q      = '0;
    fader_hi_q = '0;
    entries    = '0;
    first_err  = StOk;
  endfunction

  function automatic logic [3:0] message_status();
    if (byte_cnt < HeaderBytes) return StShort;
    if (first_err == StVersion) return StVersion;
    if (count_q == 0) return StZeroCnt;
    if (int'(byte_cnt) != HeaderBytes + TripleBytes * int'(count_q)) return StLength;
    if (gen_q == 0) return StZeroGen;
    if (count_q > MAX_SOURCES) return StTooMany;
    return first_err;
  endfunction

  // advances the message state by one byte and queues the results it causes
  function automatic void parse_byte(input logic [7:0] b, input logic eom);
    logic [BcntW-1:0] pos;
    logic [15:0]      fader;
    logic [3:0]       err;
    amp_result_t      res;
    int unsigned      stored;
    pos = byte_cnt;
    if (byte_cnt != BcntMax) byte_cnt = byte_cnt + 1'b1;
    if (pos == 0) begin
      if (b != version_q && first_err == StOk) first_err = StVersion;
    end else if (pos == 1) begin
      gen_q[15:8] = b;
    end else if (pos == 2) begin
      gen_q[7:0] = b;
    end else if (pos == 3) begin
      count_q = b;
    end else if (triple_q == TRIP_KEY) begin
      key_q    = b;
      triple_q = TRIP_FADER_HI;
    end else if (triple_q == TRIP_FADER_HI) begin
      fader_hi_q = b;
      triple_q   = TRIP_FADER_LO;
    end else begin
      fader    = {fader_hi_q, b};
      triple_q = TRIP_KEY;
      err      = StOk;
      stored   = (entries < MAX_SOURCES) ? entries : MAX_SOURCES;
      if (key_q == 0) begin
        err = StZeroKey;
      end else if (fader >= fader_limit_q) begin
        err = StFader;
      end else begin
        for (int unsigned k = 0; k < stored; k++) begin
          if (key_mem[k] == key_q) err = StDupKey;
        end
      end
      if (err != StOk && first_err == StOk) first_err = err;
      if (entries < MAX_SOURCES) key_mem[entries] = key_q;
      res             = '0;
      res.kind        = KindEntry;
      res.entry_index = entries[2:0];
      res.source_key  = key_q;
      res.fader_id    = fader;
      awaited_results.push_back(res);
      if (entries != 8'hFF) entries = entries + 1'b1;
    end
    if (eom) begin
      res              = '0;
      res.kind         = KindVerdict;
      res.generation   = gen_q;
      res.source_count = count_q;
      res.status       = message_status();
      res.last         = 1'b1;
      awaited_results.push_back(res);
      clear_message();
    end
  endfunction

  function automatic int unsigned field_diff(input string name, input logic [15:0] want,
                                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t checker: %s mismatch, expected 0x%0h actual 0x%0h",
               $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic void compare_result(input amp_result_t want, input amp_result_t got,
                                         input logic pad);
    int unsigned bad;
    bad = 0;
    bad += field_diff("kind", 16'(want.kind), 16'(got.kind));
    bad += field_diff("entry_index", 16'(want.entry_index), 16'(got.entry_index));
    bad += field_diff("source_key", 16'(want.source_key), 16'(got.source_key));
    bad += field_diff("fader_id", want.fader_id, got.fader_id);
    bad += field_diff("generation", want.generation, got.generation);
    bad += field_diff("source_count", 16'(want.source_count), 16'(got.source_count));
    bad += field_diff("status", 16'(want.status), 16'(got.status));
    bad += field_diff("last", 16'(want.last), 16'(got.last));
    bad += field_diff("tdata pad", 16'd0, 16'(pad));
    if (bad != 0) fails++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    amp_result_t got;
    if (!rst_ni) begin
      version_q     = VersionRst;
      fader_limit_q = FaderLimitRst;
      clear_message();
      awaited_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == RegVersion) version_q = pwdata_i[7:0];
        else fader_limit_q = pwdata_i[15:0];
      end
      if (m_valid_i && m_ready_i) begin
        got.kind         = m_user_i;
        got.entry_index  = m_data_i[2:0];
        got.source_key   = m_data_i[10:3];
        got.fader_id     = m_data_i[26:11];
        got.generation   = m_data_i[42:27];
        got.source_count = m_data_i[50:43];
        got.status       = m_data_i[54:51];
        got.last         = m_last_i;
        if (awaited_results.size() == 0) begin
          $display("%0t checker: unexpected result, actual 0x%0h", $time, got);
          fails++;
        end else begin
          compare_result(awaited_results.pop_front(), got, m_data_i[OutDataW-1]);
        end
      end
      if (s_valid_i && s_ready_i) parse_byte(s_data_i, s_last_i);
    end
    fail_count_o <= fails;
    pending_o    <= awaited_results.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// top of the accept-map message parser testbench: clock, reset, message stimulus,
// config writes, output back-pressure, watchdog and verdict
// depends on amp_pkg, accept_map_message_parser and amp_checker
module testbench;
  import amp_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned SettleCycles  = 4;   // margin after the last result
  localparam int unsigned PhaseBytes    = 100;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned LongMsgBytes  = 1030;

  // ways a generated message breaks the rules
  typedef enum int unsigned {
    FaultNone,
    FaultVersion,
    FaultZeroCount,
    FaultLength,
    FaultZeroGen,
    FaultTooMany,
    FaultZeroKey,
    FaultFader,
    FaultDupKey,
    FaultCount
  } msg_fault_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;   // [7:0] msg_byte
  logic                s_axis_tlast_i;   // end_of_message
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // [2:0] entry_index, [10:3] source_key, [26:11] fader_id, [42:27] generation,
  // [50:43] source_count, [54:51] status, [55] zero
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;   // [0] kind
  logic                m_axis_tlast_o;   // last
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending;

  // current config, mirrored here so that messages can be built around it
  logic [7:0]  cur_version;
  logic [15:0] cur_limit;

  logic [7:0]  msg_q[$];
  int unsigned burst_left;
  int unsigned bytes_sent;
  int unsigned idle_cycles;

  // long receiver hold-off: stimulus bumps hold_req, the receiver answers with hold_ack
  int unsigned hold_req;
  int unsigned hold_ack;

  accept_map_message_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  amp_checker #(
    .MAX_SOURCES (MaxSourcesDef)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_i    (s_axis_tready_o),
    .s_data_i     (s_axis_tdata_i),
    .s_last_i     (s_axis_tlast_i),
    .m_valid_i    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_i     (m_axis_tdata_o),
    .m_user_i     (m_axis_tuser_o),
    .m_last_i     (m_axis_tlast_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offers one byte and waits for its request to be taken; the sender runs in
  // bursts, and only lowers tvalid when a real gap follows
  task automatic push_byte(input logic [7:0] b, input logic eom);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eom;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
  endtask

  task automatic send_message();
    for (int unsigned k = 0; k < msg_q.size(); k++) begin
      push_byte(msg_q[k], k == msg_q.size() - 1);
    end
  endtask

  // stop offering and wait until every predicted result has come out; the checker
  // registers its pending count, so the task waits for a clock edge before reading it
  task automatic wait_parser_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // both registers back to back; psel stays high between the two requests
  task automatic write_config(input logic [7:0] ver, input logic [15:0] lim);
    logic [31:0] filler;
    for (int unsigned k = 0; k < 2; k++) begin
      filler = $urandom;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= (k == 0) ? {RegVersion, 2'b00} : {RegFaderLimit, 2'b00};
      // upper bits beyond the register width are don't-care
      pwdata  <= (k == 0) ? {filler[31:8], ver} : {filler[31:16], lim};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_version = ver;
    cur_limit   = lim;
  endtask

  // builds one message into msg_q: random content, well-formed or over the source
  // limit, some with a single planted fault, some plain noise
  task automatic build_message();
    int unsigned pick;
    int unsigned n_ent;
    int unsigned victim;
    int unsigned len;
    msg_fault_e  fault;
    logic [7:0]  keys[$];
    logic [15:0] faders[$];
    logic [7:0]  kb;
    logic [15:0] gen;
    logic [7:0]  ver;
    bit          taken;
    msg_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      len = $urandom_range(1, 24);
      repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    fault = (pick < 55) ? FaultNone : msg_fault_e'($urandom_range(1, FaultCount - 1));
    n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxSourcesDef + 1, MaxSourcesDef + 4)
                                        : $urandom_range(1, MaxSourcesDef);
    if (fault == FaultTooMany) n_ent = $urandom_range(MaxSourcesDef + 1, MaxSourcesDef + 8);
    if (fault == FaultZeroCount) n_ent = 0;
    gen = 16'($urandom_range(1, 65535));
    if (fault == FaultZeroGen) gen = '0;
    ver = cur_version;
    if (fault == FaultVersion) ver = cur_version ^ 8'($urandom_range(1, 255));

    // distinct nonzero keys, faders below the limit
    for (int unsigned k = 0; k < n_ent; k++) begin
      do begin
        kb    = 8'($urandom_range(1, 255));
        taken = 1'b0;
        foreach (keys[j]) if (keys[j] == kb) taken = 1'b1;
      end while (taken);
      keys.push_back(kb);
      faders.push_back(16'($urandom_range(0, int'(cur_limit) - 1)));
    end
    if (n_ent != 0) begin
      victim = $urandom_range(0, n_ent - 1);
      case (fault)
        FaultZeroKey: keys[victim] = '0;
        FaultFader:   faders[victim] = 16'($urandom_range(int'(cur_limit), 65535));
        FaultDupKey: begin
          if (n_ent > 1) begin
            victim = $urandom_range(1, n_ent - 1);
            keys[victim] = keys[$urandom_range(0, victim - 1)];
          end
        end
        default: ;
      endcase
    end

    msg_q.push_back(ver);
    msg_q.push_back(gen[15:8]);
    msg_q.push_back(gen[7:0]);
    msg_q.push_back(8'(n_ent));
    for (int unsigned k = 0; k < n_ent; k++) begin
      msg_q.push_back(keys[k]);
      msg_q.push_back(faders[k][15:8]);
      msg_q.push_back(faders[k][7:0]);
    end
    // length off by one to five extra bytes, or cut short by one or two
    if (fault == FaultLength) begin
      if ($urandom_range(0, 1) == 0 || msg_q.size() < 6) begin
        repeat ($urandom_range(1, 5)) msg_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 2)) void'(msg_q.pop_back());
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0]  ph_ver;
    logic [15:0] ph_lim;
    logic [15:0] gen;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    cur_version = VersionRst;
    cur_limit   = FaderLimitRst;
    burst_left  = 0;
    bytes_sent  = 0;
    hold_req    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset config
    // clean one-entry message, fader one below the limit
    msg_q = '{8'h01, 8'h00, 8'h01, 8'h01, 8'h05, 8'h00, 8'h95};
    send_message();
    // one-byte message: too short even though the version is also wrong
    msg_q = '{8'hFF};
    send_message();
    // header only with wrong version, zero generation and zero count
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_message();
    // zero key first, then fader at the limit, then a duplicate key at the
    // maximum fader, with the all-ones generation
    msg_q = '{8'h01, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h00,
              8'h07, 8'h00, 8'h96, 8'h07, 8'hFF, 8'hFF};
    send_message();
    wait_parser_idle();

    // random part, one config setting per phase: the extremes first
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin ph_ver = 8'd0;   ph_lim = 16'd1;     end
        1: begin ph_ver = 8'd255; ph_lim = 16'd65535; end
        2: begin ph_ver = VersionRst; ph_lim = FaderLimitRst; end
        default: begin
          ph_ver = 8'($urandom_range(0, 255));
          ph_lim = 16'($urandom_range(1, 65535));
        end
      endcase
      write_config(ph_ver, ph_lim);
      bytes_sent = 0;
      // receiver holds off for a long while so the parser backs up into its input
      if (ph == 2) hold_req++;
      while (bytes_sent < PhaseBytes) begin
        build_message();
        send_message();
      end
      // one overlong message: byte count and entry counter both saturate
      if (ph == 3) begin
        gen = 16'($urandom_range(1, 65535));
        msg_q.delete();
        msg_q.push_back(cur_version);
        msg_q.push_back(gen[15:8]);
        msg_q.push_back(gen[7:0]);
        msg_q.push_back(8'($urandom_range(0, 255)));
        repeat (LongMsgBytes) msg_q.push_back(8'($urandom_range(0, 255)));
        send_message();
      end
      wait_parser_idle();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver back-pressure: stretches of always-ready, random stalls and a fixed
  // stall pattern, plus the long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    m_axis_tready_i <= 1'b0;
    hold_ack = 0;
    forever begin
      if (hold_req != hold_ack) begin
        m_axis_tready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_ack = hold_req;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(8, 64);
        for (int unsigned k = 0; k < span; k++) begin
          case (mode)
            0:       m_axis_tready_i <= 1'b1;
            1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready_i <= (k % 5 != 4);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // watchdog: too long without any request taken on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

[files.f]
rtl/core/amp_pkg.sv
rtl/core/amp_ctrl.sv
rtl/core/amp_dpath.sv
rtl/core/accept_map_message_parser.sv
tb/amp_checker.sv
tb/testbench.sv
